// ===== hdl/bprc_pkg.sv =====
// ----------------------------------------------------------------------------
// bprc_pkg
// Shared constants for the buffer pool allocator: operation and status codes,
// fixed port widths and parameter defaults.
// ----------------------------------------------------------------------------
package bprc_pkg;

  // Fixed widths of the beat fields.
  localparam int KIND_W   = 2;
  localparam int SLOT_W   = 3;
  localparam int STATUS_W = 3;
  localparam int CNT_W    = 8;
  localparam int FREE_W   = 4;

  // Parameter defaults.
  localparam int DEF_POOL_SLOTS = 8;
  localparam int DEF_COUNT_BITS = 8;

  // Operation codes.
  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADDREF  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] STAT_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_UNREF = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_FREE  = 3'd4;

endpackage

// ===== hdl/bprc_ram.sv =====
// ----------------------------------------------------------------------------
// bprc_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module bprc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/buffer_pool_refcount_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// buffer_pool_refcount_allocator_unit
// Fixed pool of buffer slots handed out from a LIFO free stack, with a
// reference count per slot. Both the stack and the counts live in RAM.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake            | Fields
//  --------+----------------------+----------------------------------------
//  in      | in_valid / in_ready  | kind, slot_index
//  out     | out_valid / out_ready| status, slot_out, ref_count_out,
//          |                      | free_count
//
//  Each request is handled as a read and a write-back: the accept edge reads
//  the count RAM and the stack RAM, and the write-back cycle in ST_EXEC
//  modifies and writes back at most one entry of each and loads the result
//  register. A new request is taken only once the write-back is done. A full
//  result register stalls the write-back cycle until the result beat is taken.
//  Reset is synchronous and takes effect at once: per-entry valid bits stand in
//  for the reset contents of both RAMs, so no clearing pass is needed.
//
module buffer_pool_refcount_allocator_unit
  import bprc_pkg::*;
#(
  parameter int POOL_SLOTS = DEF_POOL_SLOTS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [KIND_W-1:0]   kind,
  input  logic [SLOT_W-1:0]   slot_index,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_W-1:0]   slot_out,
  output logic [CNT_W-1:0]    ref_count_out,
  output logic [FREE_W-1:0]   free_count
);

  localparam int SLOT_BITS  = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int TOTAL_BITS = $clog2(POOL_SLOTS + 1);
  localparam int WIDE_W     = 7;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  localparam logic [TOTAL_BITS-1:0] TOTAL_FULL = TOTAL_BITS'(POOL_SLOTS);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE  = COUNT_BITS'(1);

  logic                  state;
  logic [TOTAL_BITS-1:0] free_total;
  logic [TOTAL_BITS-1:0] free_total_next;
  logic [POOL_SLOTS-1:0] cnt_vld;
  logic [POOL_SLOTS-1:0] stk_vld;

  // Request captured at the accept edge.
  logic [KIND_W-1:0]     rd_kind;
  logic [SLOT_W-1:0]     rd_slot;
  logic                  rd_slot_ok;
  logic                  rd_cnt_vld;
  logic [SLOT_BITS-1:0]  rd_top_addr;
  logic                  rd_stk_vld;

  logic                  accept;
  logic                  done;
  logic [WIDE_W-1:0]     slot_wide;
  logic                  slot_ok;
  logic [SLOT_BITS-1:0]  slot_addr;
  logic [SLOT_BITS-1:0]  top_addr;

  logic                  cnt_we;
  logic [SLOT_BITS-1:0]  cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic [COUNT_BITS-1:0] cnt_rdata;
  logic                  stk_we;
  logic [SLOT_BITS-1:0]  stk_waddr;
  logic [SLOT_BITS-1:0]  stk_wdata;
  logic [SLOT_BITS-1:0]  stk_rdata;

  logic [COUNT_BITS-1:0] cur_cnt;
  logic [SLOT_BITS-1:0]  top_slot;
  logic [COUNT_BITS-1:0] dec_cnt;
  logic [STATUS_W-1:0]   res_status;
  logic [SLOT_W-1:0]     res_slot;
  logic [COUNT_BITS-1:0] res_cnt;

  // Handshake and request decode.
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign done      = (state == ST_EXEC) && (!out_valid || out_ready);
  assign slot_wide = WIDE_W'(slot_index);
  assign slot_ok   = (slot_wide < WIDE_W'(POOL_SLOTS));
  assign slot_addr = slot_wide[SLOT_BITS-1:0];
  assign top_addr  = SLOT_BITS'(free_total - TOTAL_BITS'(1));

  // Reference count store.
  bprc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (POOL_SLOTS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (accept),
    .raddr (slot_addr),
    .rdata (cnt_rdata)
  );

  // Free slot stack.
  bprc_ram #(
    .WIDTH (SLOT_BITS),
    .DEPTH (POOL_SLOTS)
  ) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (accept),
    .raddr (top_addr),
    .rdata (stk_rdata)
  );

  // Entries never written since reset read as their reset contents.
  assign cur_cnt  = (rd_slot_ok && rd_cnt_vld) ? cnt_rdata : '0;
  assign top_slot = rd_stk_vld ? stk_rdata : rd_top_addr;
  assign dec_cnt  = cur_cnt - COUNT_ONE;

  // Modify step: decide the result and the write-back for both stores.
  always_comb begin
    res_status      = STAT_OK;
    res_slot        = rd_slot;
    res_cnt         = cur_cnt;
    free_total_next = free_total;
    cnt_we          = 1'b0;
    cnt_wdata       = cur_cnt;
    stk_we          = 1'b0;
    stk_waddr       = SLOT_BITS'(free_total);
    stk_wdata       = SLOT_BITS'(WIDE_W'(rd_slot));
    cnt_waddr       = SLOT_BITS'(WIDE_W'(rd_slot));
    case (rd_kind)
      KIND_ALLOC: begin
        if (free_total == '0) begin
          res_status = STAT_EMPTY;
          res_slot   = '0;
          res_cnt    = '0;
        end else begin
          free_total_next = free_total - TOTAL_BITS'(1);
          cnt_we          = done;
          cnt_waddr       = top_slot;
          cnt_wdata       = COUNT_ONE;
          res_slot        = SLOT_W'(top_slot);
          res_cnt         = COUNT_ONE;
        end
      end
      KIND_ADDREF: begin
        if (cur_cnt == '0) begin
          res_status = STAT_FREE;
        end else if (cur_cnt == COUNT_MAX) begin
          res_status = STAT_FULL;
        end else begin
          cnt_we    = done;
          cnt_wdata = cur_cnt + COUNT_ONE;
          res_cnt   = cur_cnt + COUNT_ONE;
        end
      end
      KIND_RELEASE: begin
        if (cur_cnt == '0) begin
          res_status = STAT_UNREF;
        end else begin
          cnt_we    = done;
          cnt_wdata = dec_cnt;
          res_cnt   = dec_cnt;
          // Last reference gone: the slot goes back on top of the stack.
          if (dec_cnt == '0 && free_total < TOTAL_FULL) begin
            stk_we          = done;
            free_total_next = free_total + TOTAL_BITS'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control state, pool occupancy and per-entry valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      free_total <= TOTAL_FULL;
      cnt_vld    <= '0;
      stk_vld    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        state <= ST_EXEC;
      end else if (done) begin
        state <= ST_IDLE;
      end
      if (done) begin
        free_total <= free_total_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cnt_we) begin
        cnt_vld[cnt_waddr] <= 1'b1;
      end
      if (stk_we) begin
        stk_vld[stk_waddr] <= 1'b1;
      end
    end
  end

  // Request fields captured alongside the RAM reads.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_kind     <= kind;
      rd_slot     <= slot_index;
      rd_slot_ok  <= slot_ok;
      rd_cnt_vld  <= cnt_vld[slot_addr];
      rd_top_addr <= top_addr;
      rd_stk_vld  <= stk_vld[top_addr];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (done) begin
      status        <= res_status;
      slot_out      <= res_slot;
      ref_count_out <= CNT_W'(res_cnt);
      free_count    <= FREE_W'(free_total_next);
    end
  end

`ifndef SYNTHESIS
  // The pool never holds more free slots than it has.
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    free_total <= TOTAL_FULL)
    else $error("free slot total exceeds pool size");

  // The occupancy only moves in a write-back cycle.
  a_total_moves: assert property (@(posedge clk) disable iff (rst)
    (free_total != $past(free_total)) |-> $past(state == ST_EXEC))
    else $error("free slot total changed outside write-back");

  // A new result only appears after a write-back cycle.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_EXEC))
    else $error("result raised without a write-back");

  // A successful allocate leaves the slot with exactly one reference.
  a_alloc_one: assert property (@(posedge clk) disable iff (rst)
    (done && rd_kind == KIND_ALLOC && res_status == STAT_OK) |->
      (cnt_we && cnt_wdata == COUNT_ONE))
    else $error("allocate did not write a count of one");
`endif

endmodule

// ===== verif/buffer_pool_refcount_allocator_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// buffer_pool_refcount_allocator_unit_tb
// Self-checking bench for the buffer pool allocator. A behavioral copy of the
// free stack and the per-slot reference counts predicts every result beat.
// A short table of directed requests comes first, then a sweep to the count
// ceiling, then mostly legal random traffic under three idling patterns.
// ----------------------------------------------------------------------------
module buffer_pool_refcount_allocator_unit_tb
  import bprc_pkg::*;
();

  localparam int POOL_N = DEF_POOL_SLOTS;
  localparam logic [CNT_W-1:0] REFS_MAX = CNT_W'((1 << DEF_COUNT_BITS) - 1);
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int RANDOM_PER_PHASE = 290;
  localparam int HOLD_AT_RESULT = 60;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 12;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DIR_ROWS = 24;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [CNT_W-1:0]    refs;
    logic [FREE_W-1:0]   free_cnt;
  } pool_result_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] idx;
    logic              typed;
    pool_result_t      want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [KIND_W-1:0]   kind = '0;
  logic [SLOT_W-1:0]   slot_index = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_out;
  logic [CNT_W-1:0]    ref_count_out;
  logic [FREE_W-1:0]   free_count;

  // Predicted pool state.
  logic [SLOT_W-1:0] free_slots [POOL_N];
  logic [FREE_W-1:0] free_depth;
  logic [CNT_W-1:0]  slot_refs [POOL_N];

  pool_result_t pending_results [$];
  int unsigned  in_idle_pct = 10;
  int unsigned  out_stall_pct = 63;
  int unsigned  error_count = 0;
  int unsigned  results_seen = 0;
  int unsigned  cycle_count = 0;

  // Directed requests. Typed rows carry a result read straight off the spec;
  // the rest are checked against the predictor.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{KIND_ADDREF,  3'd3, 1'b1, '{STAT_FREE,  3'd3, 8'd0, 4'd8}},
    '{KIND_RELEASE, 3'd0, 1'b1, '{STAT_UNREF, 3'd0, 8'd0, 4'd8}},
    '{KIND_SPARE,   3'd5, 1'b1, '{STAT_OK,    3'd5, 8'd0, 4'd8}},
    '{KIND_ALLOC,   3'd2, 1'b1, '{STAT_OK,    3'd7, 8'd1, 4'd7}},
    '{KIND_ALLOC,   3'd5, 1'b1, '{STAT_OK,    3'd6, 8'd1, 4'd6}},
    '{KIND_ALLOC,   3'd0, 1'b0, '0},
    '{KIND_ALLOC,   3'd7, 1'b0, '0},
    '{KIND_ALLOC,   3'd0, 1'b0, '0},
    '{KIND_ALLOC,   3'd0, 1'b0, '0},
    '{KIND_ALLOC,   3'd0, 1'b0, '0},
    '{KIND_ALLOC,   3'd0, 1'b1, '{STAT_OK,    3'd0, 8'd1, 4'd0}},
    '{KIND_ALLOC,   3'd6, 1'b1, '{STAT_EMPTY, 3'd0, 8'd0, 4'd0}},
    '{KIND_ADDREF,  3'd7, 1'b0, '0},
    '{KIND_ADDREF,  3'd7, 1'b0, '0},
    '{KIND_RELEASE, 3'd7, 1'b0, '0},
    '{KIND_RELEASE, 3'd7, 1'b0, '0},
    '{KIND_RELEASE, 3'd7, 1'b1, '{STAT_OK,    3'd7, 8'd0, 4'd1}},
    '{KIND_RELEASE, 3'd7, 1'b1, '{STAT_UNREF, 3'd7, 8'd0, 4'd1}},
    '{KIND_ADDREF,  3'd7, 1'b1, '{STAT_FREE,  3'd7, 8'd0, 4'd1}},
    '{KIND_SPARE,   3'd6, 1'b0, '0},
    '{KIND_ALLOC,   3'd1, 1'b1, '{STAT_OK,    3'd7, 8'd1, 4'd0}},
    '{KIND_RELEASE, 3'd0, 1'b0, '0},
    '{KIND_RELEASE, 3'd3, 1'b0, '0},
    '{KIND_ALLOC,   3'd4, 1'b0, '0}
  };

  buffer_pool_refcount_allocator_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .slot_index    (slot_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .slot_out      (slot_out),
    .ref_count_out (ref_count_out),
    .free_count    (free_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Put the predicted pool in its reset state.
  task automatic pool_reset();
    for (int i = 0; i < POOL_N; i++) begin
      free_slots[i] = SLOT_W'(i);
      slot_refs[i]  = '0;
    end
    free_depth = FREE_W'(POOL_N);
  endtask

  // Apply one request to the predicted pool and return its result.
  function automatic pool_result_t pool_apply(logic [KIND_W-1:0] op,
                                              logic [SLOT_W-1:0] idx);
    pool_result_t r;
    logic [CNT_W-1:0] cnt;
    cnt = slot_refs[idx];
    r = '{STAT_OK, idx, cnt, free_depth};
    case (op)
      KIND_ALLOC: begin
        if (free_depth == 0) begin
          r = '{STAT_EMPTY, '0, '0, '0};
        end else begin
          free_depth = free_depth - 1'b1;
          r.slot = free_slots[free_depth];
          slot_refs[r.slot] = 8'd1;
          r.refs = 8'd1;
          r.free_cnt = free_depth;
        end
      end
      KIND_ADDREF: begin
        if (cnt == 0) begin
          r.status = STAT_FREE;
        end else if (cnt == REFS_MAX) begin
          r.status = STAT_FULL;
        end else begin
          slot_refs[idx] = cnt + 1'b1;
          r.refs = cnt + 1'b1;
        end
      end
      KIND_RELEASE: begin
        if (cnt == 0) begin
          r.status = STAT_UNREF;
        end else begin
          cnt = cnt - 1'b1;
          slot_refs[idx] = cnt;
          // The last reference gone puts the slot back on the free stack.
          if (cnt == 0 && free_depth < POOL_N) begin
            free_slots[free_depth] = idx;
            free_depth = free_depth + 1'b1;
          end
          r.refs = cnt;
          r.free_cnt = free_depth;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR @%0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Offer one request beat, wait for it to be taken, and queue its result.
  task automatic send_request(logic [KIND_W-1:0] op, logic [SLOT_W-1:0] idx,
                              logic typed, pool_result_t want);
    pool_result_t predicted;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= op;
    slot_index <= idx;
    do @(posedge clk); while (!in_ready);
    predicted = pool_apply(op, idx);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Mostly legal traffic on live slots, with a little noise of any kind.
  task automatic send_random();
    logic [SLOT_W-1:0] live [$];
    int unsigned roll;
    logic [KIND_W-1:0] op;
    logic [SLOT_W-1:0] idx;
    for (int i = 0; i < POOL_N; i++) begin
      if (slot_refs[i] != 0) live.push_back(SLOT_W'(i));
    end
    roll = $urandom_range(99);
    idx  = SLOT_W'($urandom_range(POOL_N - 1));
    if (roll < 6) begin
      op = KIND_W'($urandom_range(3));
    end else if (roll < 36 || live.size() == 0) begin
      op = KIND_ALLOC;
    end else begin
      op  = (roll < 62) ? KIND_ADDREF : KIND_RELEASE;
      idx = live[$urandom_range(live.size() - 1)];
    end
    send_request(op, idx, 1'b0, '0);
  endtask

  // Result side: random back-pressure, one long hold-off, and the checks.
  initial begin
    int unsigned hold_left;
    bit hold_done;
    pool_result_t exp_res;
    hold_left = 0;
    hold_done = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("result beat with nothing pending, status", status, 0);
        end else begin
          exp_res = pending_results.pop_front();
          if (status !== exp_res.status)
            report_mismatch("status", status, exp_res.status);
          if (slot_out !== exp_res.slot)
            report_mismatch("slot_out", slot_out, exp_res.slot);
          if (ref_count_out !== exp_res.refs)
            report_mismatch("ref_count_out", ref_count_out, exp_res.refs);
          if (free_count !== exp_res.free_cnt)
            report_mismatch("free_count", free_count, exp_res.free_cnt);
        end
        if (results_seen == HOLD_AT_RESULT && !hold_done) begin
          hold_left = HOLD_CYCLES;
          hold_done = 1'b1;
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  // Watchdog on the cycle count.
  initial begin
    do begin
      @(posedge clk);
      cycle_count++;
    end while (cycle_count < CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // Request side and end of test.
  initial begin
    pool_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_request(dir_rows[i].kind, dir_rows[i].idx, dir_rows[i].typed, dir_rows[i].want);

    // Drive slot 4 up to the count ceiling, one past it, then back to free.
    for (int i = 0; i < 254; i++) send_request(KIND_ADDREF, 3'd4, 1'b0, '0);
    send_request(KIND_ADDREF, 3'd4, 1'b1, '{STAT_FULL, 3'd4, 8'd255, 4'd1});
    for (int i = 0; i < 255; i++) send_request(KIND_RELEASE, 3'd4, 1'b0, '0);

    for (int i = 0; i < RANDOM_PER_PHASE; i++) send_random();
    in_idle_pct   = 63;
    out_stall_pct = 10;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) send_random();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) send_random();
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
